// ===== design/lfcim_pkg.sv =====
// ---------------------------------------------------------------------------
// Line filter package
// Shared constants, types and the ASCII case fold for the line filter.
// ---------------------------------------------------------------------------
package lfcim_pkg;

   localparam int MAX_PATTERN = 16;
   localparam int MAX_LINE    = 4096;
   localparam int BYTE_W      = 8;
   localparam int PAT_W       = MAX_PATTERN * BYTE_W;
   localparam int PAT_IDX_W   = $clog2(MAX_PATTERN);
   localparam int PLEN_W      = $clog2(MAX_PATTERN + 1);
   localparam int LINE_W      = $clog2(MAX_LINE + 1);
   localparam int HIST_DEPTH  = MAX_PATTERN - 1;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 64;
   localparam int CFG_LEN_W   = 5;

   localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;
   localparam logic [BYTE_W-1:0] UPPER_A      = 8'h41;
   localparam logic [BYTE_W-1:0] UPPER_Z      = 8'h5A;
   localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'h20;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_LOW  = 2'd0,
      CSR_PATTERN_HIGH = 2'd1,
      CSR_PATTERN_LEN  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              live;
   } cell_data_type;

   typedef struct packed {
      logic hit;
      logic pass_all;
   } match_type;

   function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] c);
      logic [BYTE_W-1:0] r;
      r = c;
      if (c >= UPPER_A && c <= UPPER_Z) begin
         r = c + CASE_OFFSET;
      end
      return r;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] fold_word(input logic [CSR_DATA_W-1:0] w);
      logic [CSR_DATA_W-1:0] r;
      r = '0;
      for (int i = 0; i < CSR_DATA_W / BYTE_W; i++) begin
         r[i*BYTE_W +: BYTE_W] = fold(w[i*BYTE_W +: BYTE_W]);
      end
      return r;
   endfunction

endpackage

// ===== design/lfcim_if.sv =====
// ---------------------------------------------------------------------------
// Line filter channels
// Valid/ready channels for text bytes, line verdicts and register writes.
// ---------------------------------------------------------------------------
interface lfcim_req_if;
   logic                            valid;
   logic                            ready;
   logic [lfcim_pkg::BYTE_W-1:0]    in_byte;
   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface lfcim_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            keep_line;
   logic                            too_long;
   logic [lfcim_pkg::LINE_W-1:0]    line_length;
   modport source (output valid, output keep_line, output too_long, output line_length,
                   input ready);
   modport sink   (input valid, input keep_line, input too_long, input line_length,
                   output ready);
endinterface

interface lfcim_csr_if;
   logic                               valid;
   logic                               ready;
   logic [lfcim_pkg::CSR_IDX_W-1:0]    index;
   logic [lfcim_pkg::CSR_DATA_W-1:0]   data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/lfcim_cell.sv =====
// ---------------------------------------------------------------------------
// Line filter history cell
// Holds one folded byte of the current line and compares it to its
// pattern byte; passes the byte to the next cell on every accepted byte and empties on a newline.
// ---------------------------------------------------------------------------
module lfcim_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          flush,
   input  lfcim_pkg::cell_data_type      shift_in,
   output lfcim_pkg::cell_data_type      shift_out,
   input  logic [lfcim_pkg::BYTE_W-1:0]  pat_byte,
   input  logic                          in_use,
   output logic                          hit
);

   logic [lfcim_pkg::BYTE_W-1:0] data_ff;
   logic                         live_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= 1'b0;
      end else if (advance) begin
         live_ff <= flush ? 1'b0 : shift_in.live;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && !flush) begin
         data_ff <= shift_in.data;
      end
   end

   assign shift_out = lfcim_pkg::cell_data_type'{data: data_ff, live: live_ff};
   assign hit       = !in_use || (live_ff && (data_ff == pat_byte));

endmodule

// ===== design/lfcim_verdict.sv =====
// ---------------------------------------------------------------------------
// Line filter verdict
// Counts line bytes, tracks a match within the line and registers one
// verdict per newline toward the result channel.
// ---------------------------------------------------------------------------
module lfcim_verdict (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic                   is_newline,
   input  lfcim_pkg::match_type   match,
   output logic                   room,
   lfcim_rsp_if.source            rsp_if
);

   localparam logic [lfcim_pkg::LINE_W-1:0] LINE_MAX =
      lfcim_pkg::LINE_W'(lfcim_pkg::MAX_LINE);

   logic [lfcim_pkg::LINE_W-1:0] count_ff;
   logic [lfcim_pkg::LINE_W-1:0] count_in;
   logic                         found_ff;
   logic                         found_in;
   logic                         valid_ff;
   logic                         valid_in;
   logic                         keep_ff;
   logic                         too_long_ff;
   logic [lfcim_pkg::LINE_W-1:0] length_ff;
   logic                         too_long;

   assign room     = !valid_ff || rsp_if.ready;
   assign too_long = (count_ff >= LINE_MAX);

   always_comb begin
      count_in = count_ff;
      found_in = found_ff;
      valid_in = valid_ff && !rsp_if.ready;
      if (accept) begin
         if (is_newline) begin
            count_in = '0;
            found_in = 1'b0;
            valid_in = 1'b1;
         end else begin
            if (count_ff < LINE_MAX) begin
               count_in = count_ff + 1'b1;
            end
            found_in = found_ff || match.hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         found_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         found_ff <= found_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_newline) begin
         keep_ff     <= (match.pass_all || found_ff) && !too_long;
         too_long_ff <= too_long;
         length_ff   <= count_ff;
      end
   end

   assign rsp_if.valid       = valid_ff;
   assign rsp_if.keep_line   = keep_ff;
   assign rsp_if.too_long    = too_long_ff;
   assign rsp_if.line_length = length_ff;

endmodule

// ===== design/line_filter_case_insensitive_match.sv =====
// ---------------------------------------------------------------------------
// Line filter with case-insensitive literal match
// Scans a byte stream line by line for a configured literal.
// ---------------------------------------------------------------------------
// Usage:
//   req_if carries one text byte per request; byte 10 ends a line.
//   rsp_if carries one verdict per newline: keep_line, too_long and the
//   line length (saturating at 4096). Other bytes give no response.
//   csr_if writes the pattern: index 0 bytes 0..7, index 1 bytes 8..15,
//   index 2 the length (0 passes every line that is not too long, above 16 acts as 16).
//   Write the pattern only while no verdict is pending.
// Throughput: one byte per cycle unless stalled; a row of 15 history cells
//   compares the last bytes against the pattern in parallel with the incoming byte.
// Latency: the verdict is valid the cycle after its newline is accepted.
// Stall: the verdict waits in an output register; while it waits and the
//   receiver holds ready low, the block takes no bytes at all.
// Reset: pattern, length, line count and match flag clear; history cells are marked empty.
// ---------------------------------------------------------------------------
module line_filter_case_insensitive_match (
   input  logic         clock,
   input  logic         reset,
   lfcim_req_if.sink    req_if,
   lfcim_rsp_if.source  rsp_if,
   lfcim_csr_if.sink    csr_if
);

   localparam int DEPTH = lfcim_pkg::HIST_DEPTH;
   localparam logic [lfcim_pkg::PLEN_W-1:0] PLEN_MAX =
      lfcim_pkg::PLEN_W'(lfcim_pkg::MAX_PATTERN);

   logic [lfcim_pkg::PAT_W-1:0]      pat_ff;
   logic [lfcim_pkg::CFG_LEN_W-1:0]  plen_ff;
   logic [lfcim_pkg::PLEN_W-1:0]     len_eff;
   logic [lfcim_pkg::PAT_IDX_W-1:0]  head_idx;
   logic [lfcim_pkg::BYTE_W-1:0]     byte_fold;
   logic                             head_hit;
   logic                             is_newline;
   logic                             room;
   logic                             accept;
   logic [DEPTH-1:0]                 hits;
   lfcim_pkg::cell_data_type         chain [0:DEPTH];
   lfcim_pkg::match_type             match;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff  <= '0;
         plen_ff <= '0;
      end else if (csr_if.valid) begin
         unique case (lfcim_pkg::csr_index_type'(csr_if.index))
            lfcim_pkg::CSR_PATTERN_LOW: begin
               pat_ff[lfcim_pkg::CSR_DATA_W-1:0] <= lfcim_pkg::fold_word(csr_if.data);
            end
            lfcim_pkg::CSR_PATTERN_HIGH: begin
               pat_ff[lfcim_pkg::PAT_W-1:lfcim_pkg::CSR_DATA_W] <=
                  lfcim_pkg::fold_word(csr_if.data);
            end
            lfcim_pkg::CSR_PATTERN_LEN: begin
               plen_ff <= csr_if.data[lfcim_pkg::CFG_LEN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign len_eff = (plen_ff > lfcim_pkg::CFG_LEN_W'(PLEN_MAX)) ? PLEN_MAX
                                                              : lfcim_pkg::PLEN_W'(plen_ff);

   assign accept      = req_if.valid && room;
   assign req_if.ready = room;
   assign byte_fold   = lfcim_pkg::fold(req_if.in_byte);
   assign is_newline  = (req_if.in_byte == lfcim_pkg::NEWLINE_BYTE);

   assign head_idx = lfcim_pkg::PAT_IDX_W'(len_eff - 1'b1);
   assign head_hit = (byte_fold == pat_ff[{head_idx, 3'b000} +: lfcim_pkg::BYTE_W]);

   assign chain[0] = lfcim_pkg::cell_data_type'{data: byte_fold, live: 1'b1};

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      logic [lfcim_pkg::PAT_IDX_W-1:0] pat_idx;
      logic                            in_use;

      assign in_use  = (lfcim_pkg::PLEN_W'(k + 1) < len_eff);
      assign pat_idx = lfcim_pkg::PAT_IDX_W'(len_eff - lfcim_pkg::PLEN_W'(k + 2));

      lfcim_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (accept),
         .flush     (is_newline),
         .shift_in  (chain[k]),
         .shift_out (chain[k+1]),
         .pat_byte  (pat_ff[{pat_idx, 3'b000} +: lfcim_pkg::BYTE_W]),
         .in_use    (in_use),
         .hit       (hits[k])
      );
   end

   assign match.pass_all = (len_eff == '0);
   assign match.hit      = !match.pass_all && head_hit && (&hits);

   lfcim_verdict u_verdict (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .is_newline (is_newline),
      .match      (match),
      .room       (room),
      .rsp_if     (rsp_if)
   );

endmodule
